// File: hdl/rsa_key_from_primes_top_assert.svh
// Assertion macros for the RTL top module
`ifndef RSA_KEY_FROM_PRIMES_TOP_ASSERT_SVH
`define RSA_KEY_FROM_PRIMES_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RKP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RKP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rkp_pkg.sv
package rkp_pkg;

    localparam int FIELD_W            = 16;
    localparam int DATA_W             = 32;
    localparam int DEFAULT_PRIME_BITS = 16;
    localparam int DIV_CNT_W          = $clog2(DATA_W);
    localparam int TDATA_IN_W         = 2 * FIELD_W;
    localparam int TDATA_OUT_W        = 4 * DATA_W;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [DATA_W-1:0] quot;
        logic [DATA_W-1:0] rem;
    } t_div_rsp;

endpackage

// File: hdl/rsa_key_from_primes_top.sv
// RSA key material from two primes p and q.
// Input stream: one request carries p (tdata[15:0]) and q (tdata[31:16]).
// Output stream: one result per request with n = p*q, phi = (p-1)*(q-1),
// the smallest public exponent e >= 2 coprime with phi, and the private
// exponent d = e^-1 mod phi in [1, phi). tuser[0] flags phi < 2 (no key),
// in which case e and d are zero.
// Factors are masked to PRIME_BITS bits before use.
// One request is in flight at a time; o_s_axis_tready is high only while
// the sequencer is idle. n and phi come from one registered 32x32 multiplier.
// e and d come from one shared restoring divider, which runs once per gcd
// division over the trial exponents and once per extended Euclid step.
// The sequencer returns to idle, ready for the next request, in the same
// cycle as the result becomes valid.
// The result stays in the output register until taken; while the receiver
// stalls, one more request can be accepted and computed, then it holds in
// the sequencer and no new request is accepted. Synchronous reset returns
// to idle with the output empty.
module rsa_key_from_primes_top
    import rkp_pkg::*;
#(
    parameter int PRIME_BITS = DEFAULT_PRIME_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_axis_tdata,  // prime_p, prime_q
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [TDATA_OUT_W-1:0] o_m_axis_tdata,  // modulus, totient, public_exp, private_exp
    output logic [0:0]             o_m_axis_tuser   // no_key
);

    localparam logic [FIELD_W-1:0] FMASK = (PRIME_BITS >= FIELD_W) ? '1 :
        FIELD_W'((32'd1 << PRIME_BITS) - 32'd1);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b00000000001,
        S_MUL_N     = 11'b00000000010,
        S_MUL_PHI   = 11'b00000000100,
        S_PHI_CHK   = 11'b00000001000,
        S_GCD_START = 11'b00000010000,
        S_GCD_WAIT  = 11'b00000100000,
        S_INV_START = 11'b00001000000,
        S_INV_WAIT  = 11'b00010000000,
        S_INV_MUL   = 11'b00100000000,
        S_INV_UPD   = 11'b01000000000,
        S_FIN       = 11'b10000000000
    } t_state;

    t_state              r_state;
    logic [FIELD_W-1:0]  r_p, r_q;
    logic [DATA_W-1:0]   r_n, r_phi, r_e;
    logic [DATA_W-1:0]   r_a, r_b, r_qt, r_rm;
    logic [DATA_W-1:0]   r_t0, r_t1;
    logic                r_t1_neg;
    logic                r_nokey;
    logic [DATA_W-1:0]   r_mul;
    logic [DATA_W-1:0]   mul_a;
    logic [DATA_W-1:0]   mul_b;
    logic [FIELD_W-1:0]  pm, qm;
    logic [DATA_W-1:0]   d_val;
    logic [DATA_W-1:0]   r_o_n, r_o_phi, r_o_e, r_o_d;
    logic                r_o_nokey;
    logic                r_o_valid;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    assign pm = (r_p != '0) ? r_p - 1'b1 : '0;
    assign qm = (r_q != '0) ? r_q - 1'b1 : '0;

    // shared multiplier, registered, low 32 bits of the product
    always_comb begin
        unique case (r_state)
            S_MUL_N: begin
                mul_a = {16'b0, r_p};
                mul_b = {16'b0, r_q};
            end
            S_MUL_PHI: begin
                mul_a = {16'b0, pm};
                mul_b = {16'b0, qm};
            end
            default: begin
                mul_a = r_qt;
                mul_b = r_t1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mul <= mul_a * mul_b;
    end

    assign div_req.start    = (r_state == S_GCD_START) || (r_state == S_INV_START);
    assign div_req.dividend = r_a;
    assign div_req.divisor  = r_b;

    rkp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Euclid coefficients alternate in sign, so magnitudes simply add
    assign d_val = r_nokey ? '0 : (r_t1_neg ? r_phi - r_t1 : r_t1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_state <= S_MUL_N;
                    end
                end
                S_MUL_N:   r_state <= S_MUL_PHI;
                S_MUL_PHI: r_state <= S_PHI_CHK;
                S_PHI_CHK: begin
                    r_state <= (r_mul < DATA_W'(2)) ? S_FIN : S_GCD_START;
                end
                S_GCD_START: r_state <= S_GCD_WAIT;
                S_GCD_WAIT: begin
                    if (div_rsp.done) begin
                        if (div_rsp.rem == '0 && r_b == DATA_W'(1)) begin
                            r_state <= S_INV_START;
                        end else begin
                            r_state <= S_GCD_START;
                        end
                    end
                end
                S_INV_START: r_state <= S_INV_WAIT;
                S_INV_WAIT: begin
                    if (div_rsp.done) begin
                        r_state <= (div_rsp.rem == '0) ? S_FIN : S_INV_MUL;
                    end
                end
                S_INV_MUL: r_state <= S_INV_UPD;
                S_INV_UPD: r_state <= S_INV_START;
                S_FIN: begin
                    if (!r_o_valid || i_m_axis_tready) begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    r_p <= i_s_axis_tdata[FIELD_W-1:0] & FMASK;
                    r_q <= i_s_axis_tdata[2*FIELD_W-1:FIELD_W] & FMASK;
                end
            end
            S_MUL_PHI: r_n <= r_mul;
            S_PHI_CHK: begin
                r_phi   <= r_mul;
                r_a     <= r_mul;
                r_b     <= DATA_W'(2);
                r_e     <= DATA_W'(2);
                r_nokey <= (r_mul < DATA_W'(2));
            end
            S_GCD_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem != '0) begin
                        r_a <= r_b;
                        r_b <= div_rsp.rem;
                    end else if (r_b == DATA_W'(1)) begin
                        // coprime: seed extended Euclid with e reduced mod phi
                        r_a      <= r_phi;
                        r_b      <= (r_e < r_phi) ? r_e : r_e - r_phi;
                        r_t0     <= '0;
                        r_t1     <= DATA_W'(1);
                        r_t1_neg <= 1'b0;
                    end else begin
                        r_e <= r_e + 1'b1;
                        r_a <= r_phi;
                        r_b <= r_e + 1'b1;
                    end
                end
            end
            S_INV_WAIT: begin
                if (div_rsp.done) begin
                    r_qt <= div_rsp.quot;
                    r_rm <= div_rsp.rem;
                end
            end
            S_INV_UPD: begin
                r_t0     <= r_t1;
                r_t1     <= r_t0 + r_mul;
                r_t1_neg <= ~r_t1_neg;
                r_a      <= r_b;
                r_b      <= r_rm;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && (!r_o_valid || i_m_axis_tready)) begin
            r_o_n     <= r_n;
            r_o_phi   <= r_phi;
            r_o_e     <= r_nokey ? '0 : r_e;
            r_o_d     <= d_val;
            r_o_nokey <= r_nokey;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o_d, r_o_e, r_o_phi, r_o_n};
    assign o_m_axis_tuser  = r_o_nokey;

    `include "rsa_key_from_primes_top_assert.svh"

    `RKP_ASSERT_IMPL(a_nokey_zero, i_clk, i_rst_n, r_o_valid && r_o_nokey,
        r_o_e == '0 && r_o_d == '0, "no-key result carries nonzero exponents")
    `RKP_ASSERT_IMPL(a_key_range, i_clk, i_rst_n, r_o_valid && !r_o_nokey,
        r_o_d != '0 && r_o_d < r_o_phi && r_o_e >= DATA_W'(2), "exponent out of range")
    `RKP_ASSERT_IMPL(a_div_free, i_clk, i_rst_n, div_req.start,
        !div_rsp.busy, "divider started while busy")
    `RKP_ASSERT_NEXT(a_accept_seq, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready,
        r_state == S_MUL_N, "accepted request did not start the sequencer")

endmodule

// File: hdl/rkp_div.sv
module rkp_div
    import rkp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DATA_W-1:0]    r_rem,  n_rem;
    logic [DATA_W-1:0]    r_quot, n_quot;
    logic [DATA_W-1:0]    r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;

    // one restoring step per cycle
    always_comb begin
        shifted = {r_rem, r_quot[DATA_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        n_rem   = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
        n_quot  = {r_quot[DATA_W-2:0], ~diff[DATA_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem  <= '0;
            r_quot <= i_req.dividend;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule
